>>> hdl/csrsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrsl_pkg
// shared types, codes and helpers of the compressed-row sparse store
// ----------------------------------------------------------------------------
package csrsl_pkg;

    localparam int KEY_W    = 24;
    localparam int COL_W    = 24;
    localparam int VAL_W    = 16;
    localparam int KCNT_W   = 13;
    localparam int STATUS_W = 3;
    localparam int ENT_W    = COL_W + VAL_W;

    localparam logic signed [VAL_W-1:0] Q14_POS = 16'sd16384;
    localparam logic signed [VAL_W-1:0] Q14_NEG = -16'sd16384;

    localparam logic CFG_FIRST_KEY = 1'b0;
    localparam logic CFG_KEY_COUNT = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_FINISH = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_RANGE     = 3'd2,
        ST_ORDER     = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOT_BUILT = 3'd5
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  first_key;
        logic [KCNT_W-1:0] key_count;
    } cfg_t;

    typedef struct packed {
        logic                    valid;
        status_t                 status;
        logic signed [VAL_W-1:0] value;
    } res_t;

    function automatic logic signed [VAL_W-1:0] sat_q14(input logic signed [VAL_W-1:0] v);
        logic signed [VAL_W-1:0] r;
        r = v;
        if (v > Q14_POS)
        begin
            r = Q14_POS;
        end
        else if (v < Q14_NEG)
        begin
            r = Q14_NEG;
        end
        return r;
    endfunction

endpackage

>>> hdl/csr_sparse_row_store_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_sparse_row_store_lookup
// compressed-row sparse matrix store with per-element binary-search lookup
// ----------------------------------------------------------------------------
// input channel (in_valid/in_ready) carries mode, key, column, value; every
// transfer gives exactly one result transfer on out_valid/out_ready with
// status and found_value. configuration goes through cfg_write, cfg_index and
// cfg_data while the block is idle: index 0 first_key, index 1 key_count.
// one item is in flight at a time; the sequencer works through it using
// two single-port rams (row pointers, packed column/value entries):
//   clear, errors: decode, then the output register
//   load: decode, row pointer writes for any skipped rows and a new row,
//   then the entry append; finish: row pointer writes for remaining rows
//   lookup: row pointer reads, then search steps, each an entry read and a
//   compare, and one more compare when a candidate entry is left
// a result waits in an output register; the next item is taken meanwhile,
// and its result is held back until the receiver takes the waiting one.
// reset empties the store (entry count, fill row, built flag) and the
// configuration registers; ram contents are left as they are.
// ----------------------------------------------------------------------------
module csr_sparse_row_store_lookup #(
    parameter int MAX_KEYS    = 4096,
    parameter int MAX_ENTRIES = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic                                cfg_index,
    input  logic [csrsl_pkg::KEY_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic [csrsl_pkg::KEY_W-1:0]         key,
    input  logic [csrsl_pkg::COL_W-1:0]         column,
    input  logic signed [csrsl_pkg::VAL_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [csrsl_pkg::STATUS_W-1:0]      status,
    output logic signed [csrsl_pkg::VAL_W-1:0]  found_value
);

    localparam int RA_W = $clog2(MAX_KEYS + 1);
    localparam int EC_W = $clog2(MAX_ENTRIES + 1);
    localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    csrsl_pkg::cfg_t                     cfg_reg;
    csrsl_pkg::res_t                     res;
    logic                                res_space;
    logic                                out_valid_reg;
    logic [csrsl_pkg::STATUS_W-1:0]      status_reg;
    logic signed [csrsl_pkg::VAL_W-1:0]  found_value_reg;

    logic                          row_we;
    logic [RA_W-1:0]               row_addr;
    logic [EC_W-1:0]               row_wdata;
    logic [EC_W-1:0]               row_rdata;
    logic                          ent_we;
    logic [EA_W-1:0]               ent_addr;
    logic [csrsl_pkg::ENT_W-1:0]   ent_wdata;
    logic [csrsl_pkg::ENT_W-1:0]   ent_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                csrsl_pkg::CFG_FIRST_KEY: cfg_reg.first_key <= cfg_data;
                csrsl_pkg::CFG_KEY_COUNT: cfg_reg.key_count <= cfg_data[csrsl_pkg::KCNT_W-1:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    // output register
    assign res_space = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg      <= res.status;
            found_value_reg <= res.value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_value = found_value_reg;

    csrsl_ctrl #(
        .MAX_KEYS    (MAX_KEYS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .column    (column),
        .value     (value),
        .cfg       (cfg_reg),
        .res_space (res_space),
        .res       (res),
        .row_we    (row_we),
        .row_addr  (row_addr),
        .row_wdata (row_wdata),
        .row_rdata (row_rdata),
        .ent_we    (ent_we),
        .ent_addr  (ent_addr),
        .ent_wdata (ent_wdata),
        .ent_rdata (ent_rdata)
    );

    // row start pointers
    csrsl_ram #(
        .WIDTH (EC_W),
        .DEPTH (MAX_KEYS + 1)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (row_wdata),
        .rdata (row_rdata)
    );

    // packed column and value entries
    csrsl_ram #(
        .WIDTH (csrsl_pkg::ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .addr  (ent_addr),
        .wdata (ent_wdata),
        .rdata (ent_rdata)
    );

endmodule

>>> hdl/csrsl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrsl_ram
// single-port synchronous ram, one write or read per cycle, registered read
// ----------------------------------------------------------------------------
module csrsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/csrsl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csrsl_ctrl
// sequencer: decode, clear, row pointer fill, entry append and binary search
// ----------------------------------------------------------------------------
module csrsl_ctrl #(
    parameter int MAX_KEYS    = 4096,
    parameter int MAX_ENTRIES = 65536,
    localparam int RA_W = $clog2(MAX_KEYS + 1),
    localparam int EC_W = $clog2(MAX_ENTRIES + 1),
    localparam int EA_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [csrsl_pkg::KEY_W-1:0]          key,
    input  logic [csrsl_pkg::COL_W-1:0]          column,
    input  logic signed [csrsl_pkg::VAL_W-1:0]   value,
    input  csrsl_pkg::cfg_t                      cfg,
    input  logic                                 res_space,
    output csrsl_pkg::res_t                      res,
    output logic                                 row_we,
    output logic [RA_W-1:0]                      row_addr,
    output logic [EC_W-1:0]                      row_wdata,
    input  logic [EC_W-1:0]                      row_rdata,
    output logic                                 ent_we,
    output logic [EA_W-1:0]                      ent_addr,
    output logic [csrsl_pkg::ENT_W-1:0]          ent_wdata,
    input  logic [csrsl_pkg::ENT_W-1:0]          ent_rdata
);

    localparam int KW = csrsl_pkg::KEY_W;
    localparam int CW = csrsl_pkg::COL_W;
    localparam int VW = csrsl_pkg::VAL_W;
    localparam logic [KW-1:0]   MAXK_K  = KW'(MAX_KEYS);
    localparam logic [EC_W-1:0] MAXE_EC = EC_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_ENTRY_WR,
        S_ROW_A,
        S_ROW_B,
        S_ROW_C,
        S_SEARCH,
        S_CMP,
        S_FINAL_RD,
        S_FINAL_CMP,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    csrsl_pkg::mode_t         mode_reg, mode_next;
    logic [KW-1:0]            key_reg, key_next;
    logic [CW-1:0]            column_reg, column_next;
    logic signed [VW-1:0]     value_reg, value_next;
    logic [EC_W-1:0]          ec_reg, ec_next;
    logic [RA_W-1:0]          nrtf_reg, nrtf_next;
    logic [CW-1:0]            last_col_reg, last_col_next;
    logic                     built_reg, built_next;
    logic [RA_W-1:0]          rel_reg, rel_next;
    logic [RA_W-1:0]          fill_idx_reg, fill_idx_next;
    logic [RA_W-1:0]          fill_end_reg, fill_end_next;
    logic [EC_W-1:0]          lo_reg, lo_next;
    logic [EC_W-1:0]          hi_reg, hi_next;
    logic [EC_W-1:0]          hend_reg, hend_next;
    logic [EC_W-1:0]          mid_reg, mid_next;
    csrsl_pkg::status_t       status_reg, status_next;
    logic signed [VW-1:0]     found_reg, found_next;

    logic [KW-1:0]   kc_k;
    logic [KW-1:0]   rows_k;
    logic [RA_W-1:0] rows_r;
    logic [KW:0]     diff;
    logic            oor;
    logic [RA_W-1:0] rel;
    logic [RA_W-1:0] rel1;
    logic            order_err;
    logic            full;
    logic [EC_W-1:0] hi_clip;
    logic [EC_W-1:0] mid;
    logic [CW-1:0]   ent_col;
    logic [VW-1:0]   ent_val;

    assign kc_k      = KW'(cfg.key_count);
    assign rows_k    = (kc_k > MAXK_K) ? MAXK_K : kc_k;
    assign rows_r    = rows_k[RA_W-1:0];
    assign diff      = {1'b0, key_reg} - {1'b0, cfg.first_key};
    assign oor       = diff[KW] || (diff[KW-1:0] >= rows_k);
    assign rel       = diff[RA_W-1:0];
    assign rel1      = rel + RA_W'(1);
    assign order_err = (nrtf_reg != '0)
                       && ((rel1 < nrtf_reg)
                           || ((rel1 == nrtf_reg) && (column_reg <= last_col_reg)));
    assign full      = (ec_reg >= MAXE_EC);
    assign hi_clip   = (row_rdata > ec_reg) ? ec_reg : row_rdata;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ent_col   = ent_rdata[csrsl_pkg::ENT_W-1:VW];
    assign ent_val   = ent_rdata[VW-1:0];

    assign in_ready   = (state_reg == S_IDLE);
    assign res.valid  = (state_reg == S_DONE) && res_space;
    assign res.status = status_reg;
    assign res.value  = found_reg;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        column_next   = column_reg;
        value_next    = value_reg;
        ec_next       = ec_reg;
        nrtf_next     = nrtf_reg;
        last_col_next = last_col_reg;
        built_next    = built_reg;
        rel_next      = rel_reg;
        fill_idx_next = fill_idx_reg;
        fill_end_next = fill_end_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        hend_next     = hend_reg;
        mid_next      = mid_reg;
        status_next   = status_reg;
        found_next    = found_reg;
        row_we        = 1'b0;
        row_addr      = rel_reg;
        row_wdata     = ec_reg;
        ent_we        = 1'b0;
        ent_addr      = lo_reg[EA_W-1:0];
        ent_wdata     = {column_reg, value_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next   = csrsl_pkg::mode_t'(mode);
                    key_next    = key;
                    column_next = column;
                    value_next  = csrsl_pkg::sat_q14(value);
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                found_next  = '0;
                status_next = csrsl_pkg::ST_OK;
                state_next  = S_DONE;
                unique case (mode_reg)
                    csrsl_pkg::MODE_LOAD:
                    begin
                        if (built_reg)
                        begin
                            status_next = csrsl_pkg::ST_ORDER;
                        end
                        else if (oor)
                        begin
                            status_next = csrsl_pkg::ST_RANGE;
                        end
                        else if (order_err)
                        begin
                            status_next = csrsl_pkg::ST_ORDER;
                        end
                        else if (full)
                        begin
                            status_next = csrsl_pkg::ST_FULL;
                        end
                        else
                        begin
                            last_col_next = column_reg;
                            if (rel1 > nrtf_reg)
                            begin
                                nrtf_next = rel1;
                            end
                            if (rel >= nrtf_reg)
                            begin
                                fill_idx_next = nrtf_reg;
                                fill_end_next = rel;
                                state_next    = S_FILL;
                            end
                            else
                            begin
                                state_next = S_ENTRY_WR;
                            end
                        end
                    end
                    csrsl_pkg::MODE_FINISH:
                    begin
                        if (built_reg)
                        begin
                            status_next = csrsl_pkg::ST_ORDER;
                        end
                        else
                        begin
                            built_next = 1'b1;
                            if (nrtf_reg <= rows_r)
                            begin
                                nrtf_next     = rows_r;
                                fill_idx_next = nrtf_reg;
                                fill_end_next = rows_r;
                                state_next    = S_FILL;
                            end
                        end
                    end
                    csrsl_pkg::MODE_LOOKUP:
                    begin
                        if (!built_reg)
                        begin
                            status_next = csrsl_pkg::ST_NOT_BUILT;
                        end
                        else if (oor)
                        begin
                            status_next = csrsl_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rel_next   = rel;
                            state_next = S_ROW_A;
                        end
                    end
                    csrsl_pkg::MODE_CLEAR:
                    begin
                        ec_next       = '0;
                        nrtf_next     = '0;
                        last_col_next = '0;
                        built_next    = 1'b0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_FILL:
            begin
                row_we   = 1'b1;
                row_addr = fill_idx_reg;
                if (fill_idx_reg == fill_end_reg)
                begin
                    state_next = (mode_reg == csrsl_pkg::MODE_LOAD) ? S_ENTRY_WR : S_DONE;
                end
                else
                begin
                    fill_idx_next = fill_idx_reg + RA_W'(1);
                end
            end
            S_ENTRY_WR:
            begin
                ent_we     = 1'b1;
                ent_addr   = ec_reg[EA_W-1:0];
                ec_next    = ec_reg + EC_W'(1);
                state_next = S_DONE;
            end
            S_ROW_A:
            begin
                row_addr   = rel_reg;
                state_next = S_ROW_B;
            end
            S_ROW_B:
            begin
                row_addr   = rel_reg + RA_W'(1);
                lo_next    = row_rdata;
                state_next = S_ROW_C;
            end
            S_ROW_C:
            begin
                hi_next    = hi_clip;
                hend_next  = hi_clip;
                lo_next    = (lo_reg > hi_clip) ? hi_clip : lo_reg;
                state_next = S_SEARCH;
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ent_addr   = mid[EA_W-1:0];
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    state_next = S_FINAL_RD;
                end
            end
            S_CMP:
            begin
                if (ent_col < column_reg)
                begin
                    lo_next = mid_reg + EC_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end
            S_FINAL_RD:
            begin
                if (lo_reg < hend_reg)
                begin
                    ent_addr   = lo_reg[EA_W-1:0];
                    state_next = S_FINAL_CMP;
                end
                else
                begin
                    status_next = csrsl_pkg::ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
            end
            S_FINAL_CMP:
            begin
                if (ent_col == column_reg)
                begin
                    status_next = csrsl_pkg::ST_OK;
                    found_next  = ent_val;
                end
                else
                begin
                    status_next = csrsl_pkg::ST_NOT_FOUND;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_space)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= csrsl_pkg::MODE_LOAD;
            key_reg      <= '0;
            column_reg   <= '0;
            value_reg    <= '0;
            ec_reg       <= '0;
            nrtf_reg     <= '0;
            last_col_reg <= '0;
            built_reg    <= 1'b0;
            rel_reg      <= '0;
            fill_idx_reg <= '0;
            fill_end_reg <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            hend_reg     <= '0;
            mid_reg      <= '0;
            status_reg   <= csrsl_pkg::ST_OK;
            found_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            key_reg      <= key_next;
            column_reg   <= column_next;
            value_reg    <= value_next;
            ec_reg       <= ec_next;
            nrtf_reg     <= nrtf_next;
            last_col_reg <= last_col_next;
            built_reg    <= built_next;
            rel_reg      <= rel_next;
            fill_idx_reg <= fill_idx_next;
            fill_end_reg <= fill_end_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            hend_reg     <= hend_next;
            mid_reg      <= mid_next;
            status_reg   <= status_next;
            found_reg    <= found_next;
        end
    end

endmodule
